/* rtl/bvpl_pkg.sv */
// shared types, register map and microcode encoding for the buck voltage pi loop
`timescale 1ns / 1ps
package bvpl_pkg;

    // default parameter values
    localparam int ADC_WIDTH_DEF = 12;
    localparam int FRAC_BITS_DEF = 12;

    // fixed field widths
    localparam int DUTY_W    = 12;
    localparam int GAIN_W    = 16;
    localparam int PERIOD_W  = 16;
    localparam int TARGET_W  = 15;
    localparam int ERR_W     = 17;
    localparam int CMP_W     = 16;
    localparam int TRIG_W    = 15;
    localparam int KGAIN_W   = 12;

    // integrator floor and the bits it needs
    localparam int INTEG_FLOOR   = 327680;
    localparam int INTEG_FLOOR_W = 19;

    // error saturation limits
    localparam int ERR_MAX_VAL = 65535;
    localparam int ERR_MIN_VAL = -65536;

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_CAL_GAIN   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CAL_OFFSET = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_DUTY   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_DUTY   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PWM_PERIOD = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BOOST_DUTY = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN = 3'd7;

    localparam logic [GAIN_W-1:0]          RST_CAL_GAIN   = 16'd4096;
    localparam logic signed [GAIN_W-1:0]   RST_CAL_OFFSET = 16'sd0;
    localparam logic [DUTY_W-1:0]          RST_MAX_DUTY   = 12'd3686;
    localparam logic [DUTY_W-1:0]          RST_MIN_DUTY   = 12'd82;
    localparam logic [PERIOD_W-1:0]        RST_PWM_PERIOD = 16'd27200;
    localparam logic [DUTY_W-1:0]          RST_BOOST_DUTY = 12'd3809;
    localparam logic [KGAIN_W-1:0]         RST_PROP_GAIN  = 12'd50;
    localparam logic [KGAIN_W-1:0]         RST_INTEG_GAIN = 12'd5;

    typedef struct packed {
        logic [GAIN_W-1:0]        cal_gain;
        logic signed [GAIN_W-1:0] cal_offset;
        logic [DUTY_W-1:0]        max_duty;
        logic [DUTY_W-1:0]        min_duty;
        logic [PERIOD_W-1:0]      pwm_period;
        logic [DUTY_W-1:0]        boost_duty;
        logic [KGAIN_W-1:0]       prop_gain;
        logic [KGAIN_W-1:0]       integ_gain;
    } cfg_t;

    // multiplier operand selection
    typedef logic [2:0] mul_op_t;
    localparam mul_op_t MUL_NONE         = 3'd0;
    localparam mul_op_t MUL_SAMPLE_GAIN  = 3'd1;
    localparam mul_op_t MUL_BOOST_PERIOD = 3'd2;
    localparam mul_op_t MUL_ERR_PROP     = 3'd3;
    localparam mul_op_t MUL_ERR_INTEG    = 3'd4;
    localparam mul_op_t MUL_DUTY_PERIOD  = 3'd5;

    // post-multiply operations
    typedef logic [2:0] alu_op_t;
    localparam alu_op_t ALU_NOP   = 3'd0;
    localparam alu_op_t ALU_ERR   = 3'd1;
    localparam alu_op_t ALU_BOOST = 3'd2;
    localparam alu_op_t ALU_DUTY  = 3'd3;
    localparam alu_op_t ALU_MIN   = 3'd4;
    localparam alu_op_t ALU_INTEG = 3'd5;
    localparam alu_op_t ALU_OUT   = 3'd6;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_MUL_CAL   = 3'd0;
    localparam step_t STEP_ERR       = 3'd1;
    localparam step_t STEP_BOOST     = 3'd2;
    localparam step_t STEP_DUTY      = 3'd3;
    localparam step_t STEP_FORCE_MIN = 3'd4;
    localparam step_t STEP_INTEG     = 3'd5;
    localparam step_t STEP_OUT       = 3'd6;
    localparam step_t STEP_LAST      = STEP_OUT;

    typedef struct packed {
        logic    jump_en;   // jump taken when the enable flag is set
        step_t   jump_to;
        logic    last;
        mul_op_t mul_op;
        alu_op_t alu_op;
    } ucode_t;

    typedef struct packed {
        logic    load;      // latch the input transaction
        logic    fire;      // execute the current control word
        mul_op_t mul_op;
        alu_op_t alu_op;
    } ctrl_t;

endpackage

/* rtl/bvpl_cfg_regs.sv */
// apb configuration register file
`timescale 1ns / 1ps
module bvpl_cfg_regs
    import bvpl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_CAL_GAIN:   cfg_next.cal_gain   = pwdata[GAIN_W-1:0];
                REG_CAL_OFFSET: cfg_next.cal_offset = $signed(pwdata[GAIN_W-1:0]);
                REG_MAX_DUTY:   cfg_next.max_duty   = pwdata[DUTY_W-1:0];
                REG_MIN_DUTY:   cfg_next.min_duty   = pwdata[DUTY_W-1:0];
                REG_PWM_PERIOD: cfg_next.pwm_period = pwdata[PERIOD_W-1:0];
                REG_BOOST_DUTY: cfg_next.boost_duty = pwdata[DUTY_W-1:0];
                REG_PROP_GAIN:  cfg_next.prop_gain  = pwdata[KGAIN_W-1:0];
                REG_INTEG_GAIN: cfg_next.integ_gain = pwdata[KGAIN_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_gain   <= RST_CAL_GAIN;
            cfg_reg.cal_offset <= RST_CAL_OFFSET;
            cfg_reg.max_duty   <= RST_MAX_DUTY;
            cfg_reg.min_duty   <= RST_MIN_DUTY;
            cfg_reg.pwm_period <= RST_PWM_PERIOD;
            cfg_reg.boost_duty <= RST_BOOST_DUTY;
            cfg_reg.prop_gain  <= RST_PROP_GAIN;
            cfg_reg.integ_gain <= RST_INTEG_GAIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CAL_GAIN:   prdata = APB_DATA_W'(cfg_reg.cal_gain);
            REG_CAL_OFFSET: prdata = APB_DATA_W'($unsigned(cfg_reg.cal_offset));
            REG_MAX_DUTY:   prdata = APB_DATA_W'(cfg_reg.max_duty);
            REG_MIN_DUTY:   prdata = APB_DATA_W'(cfg_reg.min_duty);
            REG_PWM_PERIOD: prdata = APB_DATA_W'(cfg_reg.pwm_period);
            REG_BOOST_DUTY: prdata = APB_DATA_W'(cfg_reg.boost_duty);
            REG_PROP_GAIN:  prdata = APB_DATA_W'(cfg_reg.prop_gain);
            REG_INTEG_GAIN: prdata = APB_DATA_W'(cfg_reg.integ_gain);
            default:        prdata = '0;
        endcase
    end

endmodule

/* rtl/bvpl_sequencer.sv */
// microcode sequencer: program rom, step counter, handshake and output valid
`timescale 1ns / 1ps
module bvpl_sequencer
    import bvpl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  logic  enable_flag,
    output ctrl_t ctrl
);

    logic   busy_reg;
    logic   busy_next;
    step_t  step_reg;
    step_t  step_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    ucode_t word;
    logic   stall;
    logic   fire;
    logic   accept;

    // control program
    always_comb
    begin
        word = '{jump_en: 1'b0, jump_to: STEP_MUL_CAL, last: 1'b0,
                 mul_op: MUL_NONE, alu_op: ALU_NOP};
        case (step_reg)
            STEP_MUL_CAL:
            begin
                word.mul_op = MUL_SAMPLE_GAIN;
            end
            STEP_ERR:
            begin
                word.mul_op = MUL_BOOST_PERIOD;
                word.alu_op = ALU_ERR;
            end
            STEP_BOOST:
            begin
                word.mul_op = MUL_ERR_PROP;
                word.alu_op = ALU_BOOST;
            end
            STEP_DUTY:
            begin
                // regulating: skip the forced minimum
                word.mul_op  = MUL_ERR_INTEG;
                word.alu_op  = ALU_DUTY;
                word.jump_en = 1'b1;
                word.jump_to = STEP_INTEG;
            end
            STEP_FORCE_MIN:
            begin
                word.alu_op = ALU_MIN;
            end
            STEP_INTEG:
            begin
                word.mul_op = MUL_DUTY_PERIOD;
                word.alu_op = ALU_INTEG;
            end
            STEP_OUT:
            begin
                word.alu_op = ALU_OUT;
                word.last   = 1'b1;
            end
            default:
            begin
                word.last = 1'b1;
            end
        endcase
    end

    assign in_ready  = !busy_reg;
    assign accept    = in_valid && in_ready;
    assign stall     = word.last && out_valid_reg && !out_ready;
    assign fire      = busy_reg && !stall;
    assign out_valid = out_valid_reg;

    assign ctrl.load   = accept;
    assign ctrl.fire   = fire;
    assign ctrl.mul_op = word.mul_op;
    assign ctrl.alu_op = word.alu_op;

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = STEP_MUL_CAL;
        end
        else if (fire)
        begin
            if (word.last)
            begin
                busy_next      = 1'b0;
                step_next      = STEP_MUL_CAL;
                out_valid_next = 1'b1;
            end
            else if (word.jump_en && enable_flag)
            begin
                step_next = word.jump_to;
            end
            else
            begin
                step_next = step_reg + step_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_MUL_CAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // the program never runs past its final word
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg <= STEP_LAST))
        else $error("step counter beyond program");

    // a finished result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && word.last && out_valid_reg && !out_ready) |=> busy_reg)
        else $error("result overwritten while output stalled");

    // output valid rises only from the final step of a running program
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg && word.last))
        else $error("output valid without finished program");

    // the forced-minimum step runs only for a disabled transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && step_reg == STEP_FORCE_MIN) |-> !enable_flag)
        else $error("forced minimum step while enabled");

endmodule

/* rtl/bvpl_datapath.sv */
// shared multiplier, post-multiply alu, integrator and output register
`timescale 1ns / 1ps
module bvpl_datapath
    import bvpl_pkg::*;
#(
    parameter int ADC_WIDTH = ADC_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  ctrl_t                    ctrl,
    input  logic [ADC_WIDTH-1:0]     adc_sample,
    input  logic [TARGET_W-1:0]      target_voltage,
    input  logic                     pwm_enable,
    output logic                     enable_flag,
    output logic [DUTY_W-1:0]        buck_duty,
    output logic [CMP_W-1:0]         buck_compare,
    output logic [TRIG_W-1:0]        sample_trigger,
    output logic [CMP_W-1:0]         boost_compare,
    output logic signed [ERR_W-1:0]  voltage_error
);

    localparam int MA_W  = ((ADC_WIDTH > ERR_W) ? ADC_WIDTH : ERR_W) + 1;
    localparam int MB_W  = GAIN_W + 1;
    localparam int P_W   = MA_W + MB_W;
    localparam int INT_W = ((DUTY_W + FRAC_BITS) > INTEG_FLOOR_W) ?
                           (DUTY_W + FRAC_BITS) : INTEG_FLOOR_W;
    localparam int U_W   = ((INT_W > P_W) ? INT_W : P_W) + 2;
    localparam int E_W   = P_W + 2;

    localparam logic signed [E_W-1:0] ERR_HI      = E_W'(ERR_MAX_VAL);
    localparam logic signed [E_W-1:0] ERR_LO      = E_W'(ERR_MIN_VAL);
    localparam logic signed [U_W-1:0] FLOOR_LIMIT = U_W'(INTEG_FLOOR);

    logic [ADC_WIDTH-1:0]    sample_reg;
    logic [TARGET_W-1:0]     target_reg;
    logic                    enable_reg;
    logic signed [P_W-1:0]   prod_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic [CMP_W-1:0]        boost_reg;
    logic [DUTY_W-1:0]       duty_reg;
    logic [INT_W-1:0]        integ_reg;
    logic [INT_W-1:0]        integ_next;

    logic [DUTY_W-1:0]       out_duty_reg;
    logic [CMP_W-1:0]        out_bc_reg;
    logic [TRIG_W-1:0]       out_trig_reg;
    logic [CMP_W-1:0]        out_boost_reg;
    logic signed [ERR_W-1:0] out_err_reg;

    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [P_W-1:0]   mul_result;
    logic signed [P_W-1:0]   prod_sh;

    logic signed [E_W-1:0]   volt;
    logic signed [E_W-1:0]   err_raw;
    logic signed [ERR_W-1:0] err_sat;

    logic signed [U_W-1:0]   integ_ext;
    logic signed [U_W-1:0]   loop_sum;
    logic signed [U_W-1:0]   loop_duty;
    logic signed [U_W-1:0]   max_ext;
    logic signed [U_W-1:0]   min_ext;
    logic signed [U_W-1:0]   ceil_ext;
    logic [DUTY_W-1:0]       duty_clamped;

    assign enable_flag = enable_reg;

    // operand selection for the shared multiplier
    always_comb
    begin
        case (ctrl.mul_op)
            MUL_SAMPLE_GAIN:
            begin
                mul_a = MA_W'(sample_reg);
                mul_b = MB_W'(cfg.cal_gain);
            end
            MUL_BOOST_PERIOD:
            begin
                mul_a = MA_W'(cfg.boost_duty);
                mul_b = MB_W'(cfg.pwm_period);
            end
            MUL_ERR_PROP:
            begin
                mul_a = MA_W'(err_reg);
                mul_b = MB_W'(cfg.prop_gain);
            end
            MUL_ERR_INTEG:
            begin
                mul_a = MA_W'(err_reg);
                mul_b = MB_W'(cfg.integ_gain);
            end
            MUL_DUTY_PERIOD:
            begin
                mul_a = MA_W'(duty_reg);
                mul_b = MB_W'(cfg.pwm_period);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_result = mul_a * mul_b;
    assign prod_sh    = prod_reg >>> FRAC_BITS;

    // calibrated voltage and saturated error
    assign volt    = E_W'(prod_sh) + E_W'(cfg.cal_offset);
    assign err_raw = E_W'($signed({1'b0, target_reg})) - volt;

    always_comb
    begin
        if (err_raw > ERR_HI)
        begin
            err_sat = ERR_W'(ERR_HI);
        end
        else if (err_raw < ERR_LO)
        begin
            err_sat = ERR_W'(ERR_LO);
        end
        else
        begin
            err_sat = err_raw[ERR_W-1:0];
        end
    end

    // integrator plus product serves both the duty and the integrator update
    assign integ_ext = U_W'($signed({1'b0, integ_reg}));
    assign loop_sum  = integ_ext + U_W'(prod_reg);
    assign loop_duty = loop_sum >>> FRAC_BITS;
    assign max_ext   = U_W'($signed({1'b0, cfg.max_duty}));
    assign min_ext   = U_W'($signed({1'b0, cfg.min_duty}));
    assign ceil_ext  = U_W'($signed({1'b0, cfg.max_duty, {FRAC_BITS{1'b0}}}));

    // min_duty wins whenever it sits above max_duty
    always_comb
    begin
        if (loop_duty < min_ext || max_ext < min_ext)
        begin
            duty_clamped = cfg.min_duty;
        end
        else if (loop_duty > max_ext)
        begin
            duty_clamped = cfg.max_duty;
        end
        else
        begin
            duty_clamped = loop_duty[DUTY_W-1:0];
        end
    end

    // ceiling checked first and also caps the floor, so it wins over the floor
    always_comb
    begin
        if (loop_sum > ceil_ext)
        begin
            integ_next = ceil_ext[INT_W-1:0];
        end
        else if (loop_sum < FLOOR_LIMIT)
        begin
            integ_next = (FLOOR_LIMIT > ceil_ext) ? ceil_ext[INT_W-1:0]
                                                  : FLOOR_LIMIT[INT_W-1:0];
        end
        else
        begin
            integ_next = loop_sum[INT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sample_reg <= adc_sample;
            target_reg <= target_voltage;
            enable_reg <= pwm_enable;
        end
        if (ctrl.fire)
        begin
            if (ctrl.mul_op != MUL_NONE)
            begin
                prod_reg <= mul_result;
            end
            case (ctrl.alu_op)
                ALU_ERR:   err_reg   <= err_sat;
                ALU_BOOST: boost_reg <= cfg.pwm_period - prod_sh[CMP_W-1:0];
                ALU_DUTY:  duty_reg  <= duty_clamped;
                ALU_MIN:   duty_reg  <= cfg.min_duty;
                ALU_OUT:
                begin
                    out_duty_reg  <= duty_reg;
                    out_bc_reg    <= prod_sh[CMP_W-1:0];
                    out_trig_reg  <= prod_sh[TRIG_W:1];
                    out_boost_reg <= boost_reg;
                    out_err_reg   <= err_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else if (ctrl.fire && ctrl.alu_op == ALU_INTEG)
        begin
            integ_reg <= integ_next;
        end
    end

    assign buck_duty      = out_duty_reg;
    assign buck_compare   = out_bc_reg;
    assign sample_trigger = out_trig_reg;
    assign boost_compare  = out_boost_reg;
    assign voltage_error  = out_err_reg;

endmodule

/* rtl/buck_voltage_pi_loop_core.sv */
// top level of the buck output-voltage pi loop
`timescale 1ns / 1ps
// Positional PI regulator for a buck output voltage. Each input transaction carries one
// raw ADC sample, the target and a PWM enable; one result transaction returns the Q12
// duty, buck compare, ADC trigger, boost compare and the saturated error. A transaction
// is accepted only while the microcode sequencer is idle; the program then runs one
// control word per cycle, except while its last step stalls, through a single shared
// multiplier, plus a forced-minimum step when pwm_enable is low. A finished result sits
// in the output register, and the next transaction is worked on while it waits; the
// program holds at its last step only if that register is still full. Configuration
// is an APB register file (byte address 4*index), user-written while idle; unchecked.
module buck_voltage_pi_loop_core
    import bvpl_pkg::*;
#(
    parameter int ADC_WIDTH = ADC_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ADC_WIDTH-1:0]     adc_sample,
    input  logic [TARGET_W-1:0]      target_voltage,
    input  logic                     pwm_enable,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [DUTY_W-1:0]        buck_duty,
    output logic [CMP_W-1:0]         buck_compare,
    output logic [TRIG_W-1:0]        sample_trigger,
    output logic [CMP_W-1:0]         boost_compare,
    output logic signed [ERR_W-1:0]  voltage_error
);

    cfg_t  cfg;
    ctrl_t ctrl;
    logic  enable_flag;

    bvpl_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bvpl_sequencer u_sequencer (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .enable_flag (enable_flag),
        .ctrl        (ctrl)
    );

    bvpl_datapath #(
        .ADC_WIDTH (ADC_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .ctrl           (ctrl),
        .adc_sample     (adc_sample),
        .target_voltage (target_voltage),
        .pwm_enable     (pwm_enable),
        .enable_flag    (enable_flag),
        .buck_duty      (buck_duty),
        .buck_compare   (buck_compare),
        .sample_trigger (sample_trigger),
        .boost_compare  (boost_compare),
        .voltage_error  (voltage_error)
    );

endmodule
